@@ hw/rtl/olmgt_pkg.sv @@
// ----------------------------------------------------------------------------
// olmgt_pkg
// types, constants and fixed-point helpers shared by the gradient tuner
// ----------------------------------------------------------------------------
package olmgt_pkg;

    localparam int unsigned MaxParams       = 4;
    localparam int unsigned DefNumParams    = 4;
    localparam int unsigned DefStateDim     = 2;
    localparam int unsigned DefInputDim     = 2;
    localparam int unsigned NumEntries      = 8;
    localparam int unsigned CfgIdxW         = 3;
    localparam int unsigned CfgDataW        = 32;

    localparam logic [31:0] MaskReset       = 32'd4027541145;
    localparam logic [23:0] RateReset       = 24'd8389;
    localparam logic signed [31:0] ParamAReset = 32'sd3355443;
    localparam logic signed [31:0] ParamBReset = 32'sd335544;
    localparam logic signed [31:0] ParamCReset = -32'sd10066330;
    localparam logic signed [31:0] ParamDReset = 32'sd3355443;

    localparam logic signed [63:0] One24    = 64'sd16777216;
    localparam logic signed [63:0] Max64    = 64'h7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] Min64    = 64'h8000_0000_0000_0000;

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_MASK   = 3'd0,
        REG_RATE   = 3'd1,
        REG_PARAM0 = 3'd2,
        REG_PARAM1 = 3'd3,
        REG_PARAM2 = 3'd4,
        REG_PARAM3 = 3'd5
    } t_reg_idx;

    // multiplier request: a*b, rounded shift right by sh, saturated to 64 bits
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         sh;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] p;
    } t_mul_rsp;

    function automatic logic signed [63:0] sat_w(input logic signed [63:0] v,
                                                 input int unsigned w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        sat_w = (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) add_sat = Max64;
        else if (a[63] && b[63] && !s[63]) add_sat = Min64;
        else add_sat = s;
    endfunction

endpackage

@@ hw/rtl/olmgt_mul.sv @@
// ----------------------------------------------------------------------------
// olmgt_mul
// shared 64x64 signed multiplier, one 32x32 partial product a cycle,
// rounded (ties away from zero) right shift and 64-bit saturation
// ----------------------------------------------------------------------------
module olmgt_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  olmgt_pkg::t_mul_req i_req,
    output olmgt_pkg::t_mul_rsp o_rsp
);
    import olmgt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_P0, S_P1, S_P2, S_P3, S_FIN} t_state;

    t_state       r_state;
    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [5:0]   r_sh;
    logic [127:0] r_acc;
    logic signed [63:0] r_p;
    logic         r_done;

    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_pp_ext;
    logic [127:0] w_rnd;
    logic [127:0] w_mag;
    logic         w_over;
    logic signed [63:0] w_res;

    always_comb begin
        w_x = 32'd0;
        w_y = 32'd0;
        w_pp_ext = 128'd0;
        case (r_state)
            S_P0: begin w_x = r_ua[31:0];  w_y = r_ub[31:0];  end
            S_P1: begin w_x = r_ua[31:0];  w_y = r_ub[63:32]; end
            S_P2: begin w_x = r_ua[63:32]; w_y = r_ub[31:0];  end
            S_P3: begin w_x = r_ua[63:32]; w_y = r_ub[63:32]; end
            default: begin w_x = 32'd0; w_y = 32'd0; end
        endcase
        w_pp = {32'd0, w_x} * {32'd0, w_y};
        case (r_state)
            S_P1, S_P2: w_pp_ext = {32'd0, w_pp, 32'd0};
            S_P3:       w_pp_ext = {w_pp, 64'd0};
            default:    w_pp_ext = {64'd0, w_pp};
        endcase
    end

    always_comb begin
        w_rnd = (r_sh == 6'd0) ? r_acc : (r_acc + (128'd1 << (r_sh - 6'd1)));
        w_mag = w_rnd >> r_sh;
        w_over = (w_mag[127:64] != 64'd0);
        if (r_neg) begin
            if (w_over || w_mag[63:0] >= 64'h8000_0000_0000_0000) w_res = Min64;
            else w_res = -$signed(w_mag[63:0]);
        end else begin
            if (w_over || w_mag[63]) w_res = Max64;
            else w_res = $signed(w_mag[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_ua  <= i_req.a[63] ? 64'(-i_req.a) : i_req.a;
                        r_ub  <= i_req.b[63] ? 64'(-i_req.b) : i_req.b;
                        r_neg <= i_req.a[63] ^ i_req.b[63];
                        r_sh  <= i_req.sh;
                        r_acc <= 128'd0;
                        r_state <= S_P0;
                    end
                end
                S_P0, S_P1, S_P2: begin
                    r_acc   <= r_acc + w_pp_ext;
                    r_state <= t_state'(r_state + 3'd1);
                end
                S_P3: begin
                    r_acc   <= r_acc + w_pp_ext;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_p     <= w_res;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;
endmodule

@@ hw/rtl/online_linear_model_gradient_tuner.sv @@
// ----------------------------------------------------------------------------
// online_linear_model_gradient_tuner
// online gradient-descent identification of a 2x2 state / 2x2 input model
// ----------------------------------------------------------------------------
//  channel   dir  signals                       payload
//  s_axis    in   tvalid tready tdata[47:0]     x0, x1, u0, u1
//  m_axis    out  tvalid tready tdata[383:0]    S00..S11, I00..I11,
//                                               sq error, error total
//  cfg       in   i_cfg_we i_cfg_idx i_cfg_data register write
//
//  every multiply goes through one shared multiplier, one product at a time;
//  an item needs 16 to 144 products, set by the mask, each issued only after
//  the previous one is done
//  s_axis_tready is high only while idle; a result word not yet taken holds
//  the next item at its last step
//  reset is synchronous and restores the register defaults
// ----------------------------------------------------------------------------
module online_linear_model_gradient_tuner #(
    parameter int unsigned NUM_PARAMS = olmgt_pkg::DefNumParams,
    parameter int unsigned STATE_DIM  = olmgt_pkg::DefStateDim,
    parameter int unsigned INPUT_DIM  = olmgt_pkg::DefInputDim
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x0[15:0] x1[31:16] u0[39:32] u1[47:40]
    input  logic [47:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // S00,S01,S10,S11,I00,I01,I10,I11 (32 each), sq error[318:256],
    // error total[381:319], zero fill
    output logic [383:0]                      m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [olmgt_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [olmgt_pkg::CfgDataW-1:0]    i_cfg_data
);
    import olmgt_pkg::*;

    localparam int unsigned PW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int unsigned NP = NUM_PARAMS + STATE_DIM + INPUT_DIM - 4;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_ERR_W, S_ENT, S_ENT_W, S_ROW, S_ROW_W,
        S_GRAD, S_GRAD_W, S_UPD, S_UPD_W, S_PRED, S_PRED_W, S_OUT
    } t_state;

    t_state r_state;
    logic [31:0] r_mask;
    logic [23:0] r_rate;
    logic signed [31:0] r_param [MaxParams];
    logic signed [31:0] r_newp  [MaxParams];
    logic signed [15:0] r_last_x [2];
    logic signed [7:0]  r_last_u [2];
    logic signed [15:0] r_x [2];
    logic signed [7:0]  r_u [2];
    logic signed [47:0] r_pred [2];
    logic [62:0] r_acc_err;
    logic [62:0] r_sq;
    logic signed [63:0] r_err [2];
    logic signed [63:0] r_ent [NumEntries];
    logic signed [63:0] r_rowv;
    logic signed [63:0] r_g;
    logic signed [63:0] r_m;
    logic [2:0]  r_skip;      // parameter index, or NP for the full model
    logic [2:0]  r_e;
    logic [2:0]  r_j;
    logic        r_k;
    logic [1:0]  r_t;
    logic        r_out_v;
    t_mul_req    r_req;
    t_mul_rsp    w_rsp;

    logic        w_full;
    logic        w_bit_ej;
    logic        w_bit_es;
    logic signed [63:0] w_row_term;
    logic signed [15:0] w_row_op;
    logic signed [47:0] w_row_prod;
    logic signed [63:0] w_sum;
    logic [63:0] w_sq_sum;
    logic signed [63:0] w_step;
    logic signed [63:0] w_newv;

    olmgt_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        w_full   = (r_skip == 3'(NP));
        w_bit_ej = r_mask[{r_j[1:0], r_e}];
        w_bit_es = r_mask[{r_skip[1:0], r_e}];
        // entry index for row k, term t: S cols then I cols
        case (r_t)
            2'd0:    w_row_op = w_full ? r_x[0] : r_last_x[0];
            2'd1:    w_row_op = w_full ? r_x[1] : r_last_x[1];
            2'd2:    w_row_op = 16'(w_full ? r_u[0] : r_last_u[0]);
            default: w_row_op = 16'(w_full ? r_u[1] : r_last_u[1]);
        endcase
        // entries are held to 32 bits, so a 32x16 product is enough
        w_row_prod = $signed(r_ent[{r_t[1], r_k, r_t[0]}][31:0]) * w_row_op;
        w_row_term = 64'(w_row_prod);
        w_sum      = r_rowv + w_row_term;
        w_sq_sum   = {1'b0, r_sq} + w_rsp.p;
        w_step     = sat_w(w_rsp.p, 40);
        w_newv     = sat_w(64'(r_param[r_j[PW-1:0]]) + w_step, 32);
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mask    <= MaskReset;
            r_rate    <= RateReset;
            r_param[0] <= ParamAReset;
            r_param[1] <= ParamBReset;
            r_param[2] <= ParamCReset;
            r_param[3] <= ParamDReset;
            r_last_x[0] <= '0; r_last_x[1] <= '0;
            r_last_u[0] <= '0; r_last_u[1] <= '0;
            r_pred[0] <= '0;  r_pred[1] <= '0;
            r_acc_err <= '0;
            r_out_v   <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (r_out_v && m_axis_tready) r_out_v <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MASK:   r_mask <= i_cfg_data;
                    REG_RATE:   r_rate <= i_cfg_data[23:0];
                    REG_PARAM0: r_param[0] <= i_cfg_data;
                    REG_PARAM1: r_param[1] <= i_cfg_data;
                    REG_PARAM2: r_param[2] <= i_cfg_data;
                    REG_PARAM3: r_param[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_x[0] <= s_axis_tdata[15:0];
                        r_x[1] <= s_axis_tdata[31:16];
                        r_u[0] <= s_axis_tdata[39:32];
                        r_u[1] <= s_axis_tdata[47:40];
                        r_err[0] <= 64'(r_pred[0]) - 64'sd256 *
                                    (64'($signed(s_axis_tdata[15:0])) - 64'(r_last_x[0]));
                        r_err[1] <= 64'(r_pred[1]) - 64'sd256 *
                                    (64'($signed(s_axis_tdata[31:16])) - 64'(r_last_x[1]));
                        r_sq <= '0;
                        r_k  <= 1'b0;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_req <= '{start: 1'b1, a: r_err[r_k], b: r_err[r_k], sh: 6'd0};
                    r_state <= S_ERR_W;
                end
                S_ERR_W: if (w_rsp.done) begin
                    r_sq <= w_sq_sum[63] ? 63'h7fff_ffff_ffff_ffff : w_sq_sum[62:0];
                    if (r_k) begin
                        r_skip <= '0;
                        r_e <= '0; r_j <= '0; r_m <= One24;
                        r_state <= S_ENT;
                    end else begin
                        r_k <= 1'b1;
                        r_state <= S_ERR;
                    end
                end
                // build entry r_e of the model with r_skip left out
                S_ENT: begin
                    if (!w_full && !w_bit_es) begin
                        r_ent[r_e] <= '0;
                        r_e <= r_e + 3'd1; r_j <= '0; r_m <= One24;
                        if (r_e == 3'd7) begin
                            r_k <= 1'b0; r_t <= '0; r_rowv <= '0; r_g <= '0;
                            r_state <= S_ROW;
                        end
                    end else if (r_j == 3'(NUM_PARAMS)) begin
                        r_ent[r_e] <= r_m;
                        r_e <= r_e + 3'd1; r_j <= '0; r_m <= One24;
                        if (r_e == 3'd7) begin
                            r_k <= 1'b0; r_t <= '0; r_rowv <= '0; r_g <= '0;
                            r_state <= S_ROW;
                        end
                    end else if (r_j == r_skip || !w_bit_ej) begin
                        r_j <= r_j + 3'd1;
                    end else begin
                        r_req <= '{start: 1'b1, a: r_m,
                                   b: 64'(w_full ? r_newp[r_j[PW-1:0]]
                                                 : r_param[r_j[PW-1:0]]),
                                   sh: 6'd24};
                        r_state <= S_ENT_W;
                    end
                end
                S_ENT_W: if (w_rsp.done) begin
                    r_m <= sat_w(w_rsp.p, 32);
                    r_j <= r_j + 3'd1;
                    r_state <= S_ENT;
                end
                // row dot product, one small product a cycle
                S_ROW: begin
                    r_rowv <= w_sum;
                    r_t <= r_t + 2'd1;
                    if (r_t == 2'd3) r_state <= w_full ? S_PRED : S_GRAD;
                end
                S_GRAD: begin
                    r_req <= '{start: 1'b1, a: r_err[r_k], b: r_rowv, sh: 6'd8};
                    r_state <= S_GRAD_W;
                end
                S_GRAD_W: if (w_rsp.done) begin
                    if (r_k) begin
                        r_req <= '{start: 1'b1,
                                   a: (add_sat(r_g, w_rsp.p) == Min64) ? Max64
                                      : -add_sat(r_g, w_rsp.p),
                                   b: 64'(r_rate), sh: 6'd24};
                        r_j <= {1'b0, r_skip[1:0]};
                        r_state <= S_UPD_W;
                    end else begin
                        r_g <= add_sat(r_g, w_rsp.p);
                        r_k <= 1'b1; r_rowv <= '0;
                        r_state <= S_ROW;
                    end
                end
                S_UPD_W: if (w_rsp.done) begin
                    r_newp[r_j[PW-1:0]] <= w_newv[31:0];
                    r_skip <= (r_skip == 3'(NUM_PARAMS - 1)) ? 3'(NP) : r_skip + 3'd1;
                    r_e <= '0; r_j <= '0; r_m <= One24;
                    r_state <= S_ENT;
                end
                S_UPD: r_state <= S_ENT;
                S_PRED: begin
                    r_req <= '{start: 1'b1, a: r_rowv, b: 64'sd1, sh: 6'd16};
                    r_state <= S_PRED_W;
                end
                S_PRED_W: if (w_rsp.done) begin
                    r_pred[r_k] <= w_rsp.p > 64'sh7fff_ffff_ffff ? 48'h7fff_ffff_ffff
                                 : (w_rsp.p < -64'sh8000_0000_0000 ? 48'h8000_0000_0000
                                 : w_rsp.p[47:0]);
                    if (r_k) r_state <= S_OUT;
                    else begin
                        r_k <= 1'b1; r_t <= '0; r_rowv <= '0;
                        r_state <= S_ROW;
                    end
                end
                S_OUT: if (!r_out_v) begin
                    for (int i = 0; i < NUM_PARAMS; i++) r_param[i] <= r_newp[i];
                    r_last_x <= r_x;
                    r_last_u <= r_u;
                    r_acc_err <= ({1'b0, r_acc_err} + {1'b0, r_sq} > 64'h7fff_ffff_ffff_ffff)
                                 ? 63'h7fff_ffff_ffff_ffff : r_acc_err + r_sq;
                    m_axis_tdata <= {2'b00,
                        (({1'b0, r_acc_err} + {1'b0, r_sq} > 64'h7fff_ffff_ffff_ffff)
                            ? 63'h7fff_ffff_ffff_ffff : r_acc_err + r_sq),
                        r_sq,
                        r_ent[7][31:0], r_ent[6][31:0], r_ent[5][31:0], r_ent[4][31:0],
                        r_ent[3][31:0], r_ent[2][31:0], r_ent[1][31:0], r_ent[0][31:0]};
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word dropped");
    a_acc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_v && !(i_cfg_we)) |=> (r_acc_err >= $past(r_acc_err)))
        else $error("error total decreased");
`endif
endmodule

@@ test/tb_online_linear_model_gradient_tuner.sv @@
// ----------------------------------------------------------------------------
// tb_online_linear_model_gradient_tuner
// self-checking bench for the online gradient-descent model tuner: a local
// fixed-point model tracks parameters and error terms, drives random and
// extreme samples across several register settings and checks every word
// ----------------------------------------------------------------------------
module tb_online_linear_model_gradient_tuner;
    timeunit 1ns;
    timeprecision 1ps;

    import olmgt_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_TOP   = 3'd7;
    localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0] MAX63 = 64'h7fff_ffff_ffff_ffff;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [7:0]  u1;
        logic signed [7:0]  u0;
        logic signed [15:0] x1;
        logic signed [15:0] x0;
    } t_sample;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [383:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    online_linear_model_gradient_tuner dut (.*);

    always #6 i_clk = ~i_clk;

    // model state
    logic [31:0]        mask_q;
    logic [23:0]        rate_q;
    logic signed [31:0] param_q [4];
    longint             prev_x [2];
    longint             prev_u [2];
    longint             pred_q [2];
    logic [63:0]        err_sum_q;

    t_sample      pending_samples [$];
    logic [383:0] expected_models [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  accepted_in = 0;
    bit  rx_hold = 1'b0;
    bit  tx_hold = 1'b0;
    int  tx_gap = 0, rx_gap = 0, tx_free = 0, rx_free = 0;
    longint walk_x [2] = '{0, 0};

    function automatic longint sat_bits(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // round(a*b / 2^sh), ties away from zero, saturated to 64 bits
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] prod;
        logic [63:0]  ua, ub, mag;
        logic         over, neg;
        ua = a < 0 ? 64'(-a) : 64'(a);
        ub = b < 0 ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        if (sh > 0) prod = (prod + (128'd1 << (sh - 1))) >> sh;
        mag = prod[63:0];
        over = |prod[127:64];
        neg = (a < 0) != (b < 0);
        if (neg) begin
            if (over || mag[63]) return I64_MIN;
            return -longint'(mag);
        end
        if (over || mag[63]) return I64_MAX;
        return longint'(mag);
    endfunction

    function automatic longint add_clip(longint a, longint b);
        if (b > 0 && a > I64_MAX - b) return I64_MAX;
        if (b < 0 && a < I64_MIN - b) return I64_MIN;
        return a + b;
    endfunction

    // skip < 0 gives the model, skip = i the partial model of parameter i
    function automatic void build_entries(int skip, output longint ent [8]);
        longint m;
        for (int e = 0; e < 8; e++) begin
            m = One24;
            if (skip >= 0 && !mask_q[8*skip+e]) begin
                ent[e] = 0;
                continue;
            end
            for (int j = 0; j < 4; j++)
                if (j != skip && mask_q[8*j+e])
                    m = sat_bits(mul_round(m, longint'(param_q[j]), 24), 32);
            ent[e] = m;
        end
    endfunction

    function automatic longint apply_row(longint ent [8], int k, longint x [2], longint u [2]);
        return ent[2*k]*x[0] + ent[2*k+1]*x[1] + ent[4+2*k]*u[0] + ent[4+2*k+1]*u[1];
    endfunction

    function automatic logic [383:0] tune_model(t_sample s);
        longint x [2], u [2], err [2], ent [8], grad [4], g, stp;
        logic [63:0] sq, sp;
        logic [383:0] word;
        x[0] = s.x0; x[1] = s.x1; u[0] = s.u0; u[1] = s.u1;
        sq = 0;
        for (int k = 0; k < 2; k++) begin
            err[k] = pred_q[k] - (x[k] - prev_x[k]) * 256;
            sp = 64'(mul_round(err[k], err[k], 0));
            sq = (sq + sp > MAX63) ? MAX63 : sq + sp;
        end
        err_sum_q = (err_sum_q + sq > MAX63) ? MAX63 : err_sum_q + sq;
        for (int i = 0; i < 4; i++) begin
            g = 0;
            build_entries(i, ent);
            for (int k = 0; k < 2; k++)
                g = add_clip(g, mul_round(err[k], apply_row(ent, k, prev_x, prev_u), 8));
            grad[i] = (g == I64_MIN) ? I64_MAX : -g;
        end
        for (int i = 0; i < 4; i++) begin
            stp = sat_bits(mul_round(grad[i], longint'(rate_q), 24), 40);
            param_q[i] = 32'(sat_bits(longint'(param_q[i]) + stp, 32));
        end
        build_entries(-1, ent);
        for (int k = 0; k < 2; k++)
            pred_q[k] = sat_bits(mul_round(apply_row(ent, k, x, u), 1, 16), 48);
        prev_x = x;
        prev_u = u;
        word = '0;
        for (int e = 0; e < 8; e++) word[32*e +: 32] = ent[e][31:0];
        word[318:256] = sq[62:0];
        word[381:319] = err_sum_q[62:0];
        return word;
    endfunction

    function automatic int draw_wait(ref int free_run);
        if (free_run > 0) begin
            free_run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) free_run = $urandom_range(5, 30);
        return $urandom_range(0, 7);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            expected_models.push_back(tune_model(t_sample'(s_axis_tdata)));
            accepted_in++;
            tx_gap = draw_wait(tx_free);
            if (tx_gap == 0 && pending_samples.size() > 0 && !tx_hold) begin
                s_axis_tdata <= pending_samples.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end else if (!s_axis_tvalid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_samples.size() > 0 && !tx_hold) begin
                s_axis_tdata  <= pending_samples.pop_front();
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        logic [383:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_models.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
                end else begin
                    want = expected_models.pop_front();
                    for (int f = 0; f < 10; f++) begin
                        if (f < 8 ? want[32*f +: 32] !== m_axis_tdata[32*f +: 32]
                                  : want[256+63*(f-8) +: 63] !== m_axis_tdata[256+63*(f-8) +: 63]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("field %0d: expected %h got %h", f,
                                         f < 8 ? 63'(want[32*f +: 32]) : want[256+63*(f-8) +: 63],
                                         f < 8 ? 63'(m_axis_tdata[32*f +: 32])
                                               : m_axis_tdata[256+63*(f-8) +: 63]);
                        end
                    end
                end
                rx_gap = draw_wait(rx_free);
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            m_axis_tready <= !rx_hold && rx_gap == 0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold while the sender keeps offering
    initial begin
        wait (accepted_in >= 60);
        rx_hold = 1'b1;
        repeat (3000) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_MASK:   mask_q = val;
            REG_RATE:   rate_q = val[23:0];
            REG_PARAM0: param_q[0] = val;
            REG_PARAM1: param_q[1] = val;
            REG_PARAM2: param_q[2] = val;
            REG_PARAM3: param_q[3] = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !s_axis_tvalid && expected_models.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample();
        t_sample s;
        if ($urandom_range(0, 2) == 0) begin
            s = t_sample'(48'({$urandom, $urandom}));
        end else begin
            // slowly moving state, the usual shape of a drive trace
            for (int k = 0; k < 2; k++)
                walk_x[k] = sat_bits(walk_x[k] + $signed($urandom_range(0, 800)) - 400, 16);
            s.x0 = 16'(walk_x[0]);
            s.x1 = 16'(walk_x[1]);
            s.u0 = 8'($signed($urandom_range(0, 254)) - 127);
            s.u1 = 8'($signed($urandom_range(0, 254)) - 127);
        end
        return s;
    endfunction

    task automatic run_random(int n);
        repeat (n) pending_samples.push_back(random_sample());
        drain();
    endtask

    initial begin
        t_sample s;
        mask_q = MaskReset;
        rate_q = RateReset;
        param_q = '{ParamAReset, ParamBReset, ParamCReset, ParamDReset};
        prev_x = '{0, 0};
        prev_u = '{0, 0};
        pred_q = '{0, 0};
        err_sum_q = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: field extremes with the reset settings
        pending_samples.push_back('{u1: 0, u0: 0, x1: 0, x0: 0});
        pending_samples.push_back('{u1: 127, u0: -127, x1: 32767, x0: -32768});
        pending_samples.push_back('{u1: -128, u0: -128, x1: -32768, x0: 32767});
        pending_samples.push_back('{u1: 127, u0: 127, x1: 32767, x0: 32767});
        pending_samples.push_back('{u1: -127, u0: 1, x1: -1, x0: 1});
        pending_samples.push_back('{u1: 0, u0: -128, x1: -32768, x0: -32768});
        pending_samples.push_back('{u1: 5, u0: 5, x1: 100, x0: 100});
        pending_samples.push_back('{u1: 5, u0: 5, x1: 100, x0: 100});
        drain();

        // unknown indexes must not disturb anything
        write_reg(REG_SPARE, $urandom);
        write_reg(REG_TOP, $urandom);
        pending_samples.push_back('{u1: 3, u0: -3, x1: 200, x0: -200});
        pending_samples.push_back('{u1: -128, u0: 127, x1: 0, x0: 0});
        drain();

        // zero mask and zero rate: model stuck at one
        write_reg(REG_MASK, 32'h0);
        write_reg(REG_RATE, 24'h0);
        run_random(40);

        // everything set, rate at its top, parameters at the extremes
        write_reg(REG_MASK, 32'hffff_ffff);
        write_reg(REG_RATE, 24'hff_ffff);
        write_reg(REG_PARAM0, 32'h7fff_ffff);
        write_reg(REG_PARAM1, 32'h8000_0000);
        write_reg(REG_PARAM2, 32'h7fff_ffff);
        write_reg(REG_PARAM3, 32'h8000_0000);
        s = '{u1: 127, u0: -128, x1: 32767, x0: -32768};
        pending_samples.push_back(s);
        run_random(60);

        write_reg(REG_MASK, 32'h0f0f_f0f0);
        write_reg(REG_PARAM0, 32'h8000_0000);
        write_reg(REG_PARAM1, 32'h8000_0000);
        write_reg(REG_PARAM2, 32'h0);
        write_reg(REG_PARAM3, 32'h0100_0000);
        run_random(60);

        // back to the reset-style setup for the long stretch
        write_reg(REG_MASK, MaskReset);
        write_reg(REG_RATE, RateReset);
        write_reg(REG_PARAM0, ParamAReset);
        write_reg(REG_PARAM1, ParamBReset);
        write_reg(REG_PARAM2, ParamCReset);
        write_reg(REG_PARAM3, ParamDReset);
        run_random(400);

        // sender pause after everything is back
        tx_hold = 1'b1;
        repeat (200) @(posedge i_clk);
        tx_hold = 1'b0;

        repeat (9) begin
            write_reg(REG_MASK, $urandom);
            write_reg(REG_RATE, $urandom_range(0, 24'hff_ffff));
            write_reg(REG_PARAM0, $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25));
            write_reg(REG_PARAM1, $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25));
            write_reg(REG_PARAM2, $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25));
            write_reg(REG_PARAM3, $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25));
            run_random(110);
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_models.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
